// ----- src/depth_pixel_backprojector_unit_assert.svh -----
// assertion macros shared by the checker
`ifndef DEPTH_PIXEL_BACKPROJECTOR_UNIT_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTOR_UNIT_ASSERT_SVH

// checked only outside reset
`define DPB_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define DPB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/dpb_pkg.sv -----
`timescale 1ns / 1ps
package dpb_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int SUBSAMPLE_DEFAULT = 3;

   localparam int COUNT_W   = 12;
   localparam int DEPTH_W   = 16;
   localparam int COLOR_W   = 8;
   localparam int WIDTH_W   = 13;
   localparam int CENTER_W  = 20;
   localparam int COEF_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 96;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCOUNT_W    = 3;

   // shared multiplier operands and product
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH = 13'd640;
   localparam logic [CENTER_W-1:0] RST_CENTER_X    = 20'd81573;
   localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 20'd65360;
   localparam logic [COEF_W-1:0]   RST_INV_FOCAL_X = 24'd32432;
   localparam logic [COEF_W-1:0]   RST_INV_FOCAL_Y = 24'd32485;
   localparam logic [COEF_W-1:0]   RST_DEPTH_SCALE = 24'd16777;
   localparam logic [COEF_W-1:0]   RST_MIN_DEPTH   = 24'd655;
   localparam logic [COEF_W-1:0]   RST_MAX_DEPTH   = 24'd655360;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH = 3'd0,
      CSR_CENTER_X    = 3'd1,
      CSR_CENTER_Y    = 3'd2,
      CSR_INV_FOCAL_X = 3'd3,
      CSR_INV_FOCAL_Y = 3'd4,
      CSR_DEPTH_SCALE = 3'd5,
      CSR_MIN_DEPTH   = 3'd6,
      CSR_MAX_DEPTH   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Z,
      ST_CHK,
      ST_AX,
      ST_HX,
      ST_LX,
      ST_SX,
      ST_HY,
      ST_LY,
      ST_SY
   } back_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] col;
      logic [COUNT_W-1:0] row;
      logic [DEPTH_W-1:0] depth;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } pix_type;

   typedef struct packed {
      logic    valid;
      pix_type pix;
   } push_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [COEF_W-1:0]   inv_focal_x;
      logic [COEF_W-1:0]   inv_focal_y;
      logic [COEF_W-1:0]   depth_scale;
      logic [COEF_W-1:0]   min_depth;
      logic [COEF_W-1:0]   max_depth;
   } cfg_type;

endpackage

// ----- src/dpb_front.sv -----
`timescale 1ns / 1ps
module dpb_front #(
   parameter int MAX_WIDTH = dpb_pkg::MAX_WIDTH_DEFAULT,
   parameter int SUBSAMPLE = dpb_pkg::SUBSAMPLE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [dpb_pkg::DEPTH_W-1:0]   in_depth,
   input  logic [dpb_pkg::COLOR_W-1:0]   in_blue,
   input  logic [dpb_pkg::COLOR_W-1:0]   in_green,
   input  logic [dpb_pkg::COLOR_W-1:0]   in_red,
   input  logic                          in_frame_start,
   input  logic [dpb_pkg::WIDTH_W-1:0]   image_width,
   input  logic                          queue_full,
   output dpb_pkg::push_type             push
);

   localparam int RES_W = $clog2(SUBSAMPLE + 1);
   localparam logic [RES_W-1:0] RES_LAST = RES_W'(SUBSAMPLE - 1);

   logic [dpb_pkg::COUNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [RES_W-1:0]            col_res_ff, col_res_in, row_res_ff, row_res_in;
   logic [dpb_pkg::COUNT_W-1:0] col, row;
   logic [RES_W-1:0]            col_res, row_res;
   logic [dpb_pkg::WIDTH_W-1:0] next_col;
   logic                        accept, wrap;

   assign in_ready = !queue_full && !reset;
   assign accept   = in_valid && in_ready;

   // frame start clears the counters before the pixel is used
   assign col     = in_frame_start ? '0 : col_ff;
   assign row     = in_frame_start ? '0 : row_ff;
   assign col_res = in_frame_start ? '0 : col_res_ff;
   assign row_res = in_frame_start ? '0 : row_res_ff;

   assign next_col = {1'b0, col} + 1'b1;
   // width zero wraps on every pixel, width above the limit wraps at the limit
   assign wrap = (next_col >= image_width) || (32'(next_col) >= MAX_WIDTH);

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      col_res_in = col_res_ff;
      row_res_in = row_res_ff;
      if (accept) begin
         if (wrap) begin
            col_in     = '0;
            col_res_in = '0;
            row_in     = row + 1'b1;
            // row counter overflow restarts the phase too
            if (row_in == '0 || row_res == RES_LAST) begin
               row_res_in = '0;
            end else begin
               row_res_in = row_res + 1'b1;
            end
            col_res_in = '0;
         end else begin
            col_in     = next_col[dpb_pkg::COUNT_W-1:0];
            row_in     = row;
            row_res_in = row_res;
            if (col_in == '0 || col_res == RES_LAST) begin
               col_res_in = '0;
            end else begin
               col_res_in = col_res + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         col_res_ff <= '0;
         row_res_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         col_res_ff <= col_res_in;
         row_res_ff <= row_res_in;
      end
   end

   always_comb begin
      push.valid     = accept && (col_res == '0) && (row_res == '0);
      push.pix.col   = col;
      push.pix.row   = row;
      push.pix.depth = in_depth;
      push.pix.blue  = in_blue;
      push.pix.green = in_green;
      push.pix.red   = in_red;
   end

endmodule

// ----- src/dpb_queue.sv -----
`timescale 1ns / 1ps
module dpb_queue (
   input  logic              clock,
   input  logic              reset,
   input  dpb_pkg::push_type push,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output dpb_pkg::pix_type  head
);

   dpb_pkg::pix_type             entry_ff [dpb_pkg::QUEUE_DEPTH];
   logic [dpb_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [dpb_pkg::QCOUNT_W-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign full    = (count_ff == dpb_pkg::QCOUNT_W'(dpb_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.pix;
      end
   end

endmodule

// ----- src/dpb_back.sv -----
`timescale 1ns / 1ps
module dpb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  dpb_pkg::cfg_type            cfg,
   input  logic                        queue_empty,
   input  dpb_pkg::pix_type            head,
   output logic                        pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [dpb_pkg::RSP_W-1:0]   out_data
);

   localparam int MAG_W = 36;
   localparam logic [dpb_pkg::COEF_W-1:0] Z_MAX   = '1;
   localparam logic [dpb_pkg::COEF_W-1:0] POS_MAX = 24'h7FFFFF;
   localparam logic [dpb_pkg::COEF_W-1:0] NEG_MAX = 24'h800000;

   dpb_pkg::back_state_type state_ff, state_in;

   logic [dpb_pkg::MUL_P_W-1:0]  prod_ff, prod_in, hi_ff, hi_in, mul_p, sum;
   logic [dpb_pkg::MUL_A_W-1:0]  mul_a;
   logic [dpb_pkg::MUL_B_W-1:0]  mul_b;
   logic [15:0]                  lo_ff, lo_in;
   logic [dpb_pkg::COEF_W-1:0]   z_ff, z_in, x_ff, x_in, z_sat, sat_val;
   logic [dpb_pkg::CENTER_W-1:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                         neg_x_ff, neg_x_in, neg_y_ff, neg_y_in, neg_sel;
   logic [dpb_pkg::CENTER_W:0]   dx, dy;
   logic [MAG_W-1:0]             mag;
   logic                         out_valid_ff, out_valid_in;
   logic [dpb_pkg::RSP_W-1:0]    out_data_ff, out_data_in;

   // one shared multiplier, operands picked by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         dpb_pkg::ST_Z: begin
            mul_a = dpb_pkg::MUL_A_W'(head.depth);
            mul_b = cfg.depth_scale;
         end
         dpb_pkg::ST_AX: begin
            mul_a = dpb_pkg::MUL_A_W'(mag_x_ff);
            mul_b = z_ff;
         end
         dpb_pkg::ST_HX: begin
            mul_a = prod_ff[43:16];
            mul_b = cfg.inv_focal_x;
         end
         dpb_pkg::ST_LX: begin
            mul_a = dpb_pkg::MUL_A_W'(lo_ff);
            mul_b = cfg.inv_focal_x;
         end
         dpb_pkg::ST_SX: begin
            mul_a = dpb_pkg::MUL_A_W'(mag_y_ff);
            mul_b = z_ff;
         end
         dpb_pkg::ST_HY: begin
            mul_a = prod_ff[43:16];
            mul_b = cfg.inv_focal_y;
         end
         dpb_pkg::ST_LY: begin
            mul_a = dpb_pkg::MUL_A_W'(lo_ff);
            mul_b = cfg.inv_focal_y;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = dpb_pkg::MUL_P_W'(mul_a) * dpb_pkg::MUL_P_W'(mul_b);

   // z from the registered depth product
   assign z_sat = (prod_ff[39:8] > 32'(Z_MAX)) ? Z_MAX : prod_ff[31:8];

   assign dx = {1'b0, head.col, 8'b0} - {1'b0, cfg.center_x};
   assign dy = {1'b0, head.row, 8'b0} - {1'b0, cfg.center_y};

   // (a * inv) >> 32 rebuilt from the high and low partial products
   assign sum = hi_ff + dpb_pkg::MUL_P_W'(prod_ff[dpb_pkg::MUL_P_W-1:16]);
   assign mag = sum[dpb_pkg::MUL_P_W-1:16];
   assign neg_sel = (state_ff == dpb_pkg::ST_SY) ? neg_y_ff : neg_x_ff;

   always_comb begin
      if (neg_sel) begin
         sat_val = (mag > MAG_W'(NEG_MAX)) ? NEG_MAX : 24'(24'd0 - mag[23:0]);
      end else begin
         sat_val = (mag > MAG_W'(POS_MAX)) ? POS_MAX : mag[23:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      prod_in      = prod_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      z_in         = z_ff;
      x_in         = x_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      pop          = 1'b0;
      out_valid_in = out_valid_ff && !out_ready;
      out_data_in  = out_data_ff;
      unique case (state_ff)
         dpb_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               state_in = dpb_pkg::ST_Z;
            end
         end
         dpb_pkg::ST_Z: begin
            prod_in  = mul_p;
            state_in = dpb_pkg::ST_CHK;
         end
         dpb_pkg::ST_CHK: begin
            z_in     = z_sat;
            neg_x_in = dx[dpb_pkg::CENTER_W];
            neg_y_in = dy[dpb_pkg::CENTER_W];
            mag_x_in = dx[dpb_pkg::CENTER_W] ? dpb_pkg::CENTER_W'(-dx)
                                             : dx[dpb_pkg::CENTER_W-1:0];
            mag_y_in = dy[dpb_pkg::CENTER_W] ? dpb_pkg::CENTER_W'(-dy)
                                             : dy[dpb_pkg::CENTER_W-1:0];
            if (z_sat >= cfg.min_depth && z_sat <= cfg.max_depth) begin
               state_in = dpb_pkg::ST_AX;
            end else begin
               pop      = 1'b1;
               state_in = dpb_pkg::ST_IDLE;
            end
         end
         dpb_pkg::ST_AX: begin
            prod_in  = mul_p;
            state_in = dpb_pkg::ST_HX;
         end
         dpb_pkg::ST_HX: begin
            lo_in    = prod_ff[15:0];
            prod_in  = mul_p;
            state_in = dpb_pkg::ST_LX;
         end
         dpb_pkg::ST_LX: begin
            hi_in    = prod_ff;
            prod_in  = mul_p;
            state_in = dpb_pkg::ST_SX;
         end
         dpb_pkg::ST_SX: begin
            // finish x while the y offset product starts
            x_in     = sat_val;
            prod_in  = mul_p;
            state_in = dpb_pkg::ST_HY;
         end
         dpb_pkg::ST_HY: begin
            lo_in    = prod_ff[15:0];
            prod_in  = mul_p;
            state_in = dpb_pkg::ST_LY;
         end
         dpb_pkg::ST_LY: begin
            hi_in    = prod_ff;
            prod_in  = mul_p;
            state_in = dpb_pkg::ST_SY;
         end
         dpb_pkg::ST_SY: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = {head.red, head.green, head.blue, z_ff, sat_val, x_ff};
               pop          = 1'b1;
               state_in     = dpb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dpb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpb_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      z_ff        <= z_in;
      x_ff        <= x_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- src/depth_pixel_backprojector_unit.sv -----
`timescale 1ns / 1ps
// Depth pixel back-projector: takes a raster stream of depth pixels with colors, keeps every
// SUBSAMPLE-th pixel of every SUBSAMPLE-th row, scales depth to Q16 meters and, when it lies
// within [min_depth, max_depth], sends out the pinhole back-projected point x, y, z with its
// color. The front end takes one pixel per cycle while the queue is not full; skipped pixels
// are taken like kept ones but never enter the queue. Kept pixels wait in a four-entry queue
// for the back end, which computes each point on one shared 28x24 multiplier: a point in
// range goes through queue pick-up, the depth check, seven products in all and the final
// saturate and hand-off (held while the output word is stalled); a point rejected by the depth
// window leaves after its depth product and check. A frame_start pixel restarts the column and
// row counters. Configuration writes take effect at once and are meant to be made while no pixel is in flight.
module depth_pixel_backprojector_unit #(
   parameter int MAX_WIDTH = dpb_pkg::MAX_WIDTH_DEFAULT,
   parameter int SUBSAMPLE = dpb_pkg::SUBSAMPLE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // depth_raw[15:0], blue[23:16], green[31:24], red[39:32]
   input  logic [dpb_pkg::REQ_W-1:0]       req_tdata,
   // frame_start
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // point_x[23:0], point_y[47:24], point_z[71:48], out_blue[79:72],
   // out_green[87:80], out_red[95:88]
   output logic [dpb_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                            csr_we,
   input  logic [dpb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpb_pkg::COEF_W-1:0]      csr_wdata
);

   logic [dpb_pkg::WIDTH_W-1:0]  image_width_ff;
   logic [dpb_pkg::CENTER_W-1:0] center_x_ff, center_y_ff;
   logic [dpb_pkg::COEF_W-1:0]   inv_focal_x_ff, inv_focal_y_ff, depth_scale_ff;
   logic [dpb_pkg::COEF_W-1:0]   min_depth_ff, max_depth_ff;

   dpb_pkg::cfg_type  cfg;
   dpb_pkg::push_type push;
   dpb_pkg::pix_type  head;
   logic              queue_full, queue_empty, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= dpb_pkg::RST_IMAGE_WIDTH;
         center_x_ff    <= dpb_pkg::RST_CENTER_X;
         center_y_ff    <= dpb_pkg::RST_CENTER_Y;
         inv_focal_x_ff <= dpb_pkg::RST_INV_FOCAL_X;
         inv_focal_y_ff <= dpb_pkg::RST_INV_FOCAL_Y;
         depth_scale_ff <= dpb_pkg::RST_DEPTH_SCALE;
         min_depth_ff   <= dpb_pkg::RST_MIN_DEPTH;
         max_depth_ff   <= dpb_pkg::RST_MAX_DEPTH;
      end else if (csr_we) begin
         unique case (csr_index)
            dpb_pkg::CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata[dpb_pkg::WIDTH_W-1:0];
            dpb_pkg::CSR_CENTER_X:    center_x_ff    <= csr_wdata[dpb_pkg::CENTER_W-1:0];
            dpb_pkg::CSR_CENTER_Y:    center_y_ff    <= csr_wdata[dpb_pkg::CENTER_W-1:0];
            dpb_pkg::CSR_INV_FOCAL_X: inv_focal_x_ff <= csr_wdata;
            dpb_pkg::CSR_INV_FOCAL_Y: inv_focal_y_ff <= csr_wdata;
            dpb_pkg::CSR_DEPTH_SCALE: depth_scale_ff <= csr_wdata;
            dpb_pkg::CSR_MIN_DEPTH:   min_depth_ff   <= csr_wdata;
            dpb_pkg::CSR_MAX_DEPTH:   max_depth_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.center_x    = center_x_ff;
      cfg.center_y    = center_y_ff;
      cfg.inv_focal_x = inv_focal_x_ff;
      cfg.inv_focal_y = inv_focal_y_ff;
      cfg.depth_scale = depth_scale_ff;
      cfg.min_depth   = min_depth_ff;
      cfg.max_depth   = max_depth_ff;
   end

   dpb_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .SUBSAMPLE (SUBSAMPLE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_depth       (req_tdata[15:0]),
      .in_blue        (req_tdata[23:16]),
      .in_green       (req_tdata[31:24]),
      .in_red         (req_tdata[39:32]),
      .in_frame_start (req_tuser),
      .image_width    (image_width_ff),
      .queue_full     (queue_full),
      .push           (push)
   );

   dpb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .empty (queue_empty),
      .head  (head)
   );

   dpb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata)
   );

endmodule

// ----- src/dpb_checker.sv -----
`timescale 1ns / 1ps
`include "depth_pixel_backprojector_unit_assert.svh"
module dpb_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [dpb_pkg::RSP_W-1:0] rsp_tdata
);

   // a pixel offered during reset must not be taken
   `DPB_ASSERT_ALWAYS(a_no_accept_in_reset, reset |-> !req_tready, "word taken during reset")

   // a point must pass through the queue and the back end after reset before it can show up
   `DPB_ASSERT_RUN(a_no_early_point, rsp_tvalid |-> !$past(reset) && !$past(reset, 2) && !$past(reset, 3), "point too soon after reset")

   // a stalled point keeps its payload
   `DPB_ASSERT_RUN(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled point changed")

endmodule

bind depth_pixel_backprojector_unit dpb_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
